FILE: rtl/mgpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgpc_pkg
// shared widths and parameter defaults for the monotone grid path cost block
// ----------------------------------------------------------------------------
package mgpc_pkg;

    localparam int MAX_SIDE_DEF    = 2048;   // largest grid side
    localparam int HEIGHT_BITS_DEF = 16;     // height bits in use
    localparam int COST_W          = 28;     // cost width, sums wrap
    localparam int SIDE_W          = 12;     // grid_side register width

endpackage : mgpc_pkg
`default_nettype wire

FILE: rtl/monotone_grid_path_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// monotone_grid_path_cost
// least cost of a right/down path over a square height grid, row-major input
// ----------------------------------------------------------------------------
// usage
//   - cfg channel (cfg_valid/cfg_ready/grid_side) sets the grid side; a write
//     also returns the scan to the top-left cell; cfg_ready is always high
//   - in channel (in_valid/in_ready/height) takes one cell per item in
//     row-major order, one item per clock sustained while out is not stalled
//   - out channel (out_valid/out_ready/total_cost) gives one item per grid,
//     on the last cell; a one-cell grid gives one item per cell
//   - result path: the last cell passes through the compute stage register
//     into the output register once the output register is free
//   - throughput: one cell per cycle unless out stalls, set by the single read
//     and single write port of the row buffer (read at accept, write at retire)
//   - a stalled receiver holds the output register; the block keeps taking
//     cells until the next grid's last cell reaches the compute stage, which
//     then waits and in_ready drops until the output register frees up
//   - reset clears control state and sets the side to 1; the line buffer is
//     not cleared since each entry is written by a row before the next reads it
// ----------------------------------------------------------------------------
module monotone_grid_path_cost #(
    parameter int MAX_SIDE    = mgpc_pkg::MAX_SIDE_DEF,
    parameter int HEIGHT_BITS = mgpc_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mgpc_pkg::SIDE_W-1:0] grid_side,
    // cells in
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [HEIGHT_BITS-1:0]      height,
    // result out
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mgpc_pkg::COST_W-1:0]      total_cost
);
    import mgpc_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIDE);
    localparam logic [IDX_W-1:0] SIDE_MAX_M1 = IDX_W'(MAX_SIDE - 1);

    typedef struct packed {
        logic [COST_W-1:0]      cost;
        logic [HEIGHT_BITS-1:0] h;
    } entry_t;

    // line buffer: cost and height of the row above
    entry_t line_mem [MAX_SIDE];
    entry_t rd_data_reg;

    // scan position and effective side minus one
    logic [IDX_W-1:0] side_m1_reg, side_m1_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;

    // compute stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [HEIGHT_BITS-1:0] s1_h_reg;
    logic [IDX_W-1:0]       s1_addr_reg;
    logic                   s1_has_up_reg, s1_has_left_reg, s1_last_reg;

    // left neighbor
    logic [COST_W-1:0]      left_cost_reg;
    logic [HEIGHT_BITS-1:0] left_h_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [COST_W-1:0] out_cost_reg;

    logic              in_acc, s1_retire, is_last, col_end;
    logic [COST_W-1:0] left_sum, up_sum, cell_cost;

    function automatic logic [COST_W-1:0] step_cost(
        input logic [HEIGHT_BITS-1:0] from_h,
        input logic [HEIGHT_BITS-1:0] to_h
    );
        logic [HEIGHT_BITS:0] d;
        begin
            if (from_h > to_h)
            begin
                d = '0;
            end
            else
            begin
                d = {1'b0, to_h} - {1'b0, from_h} + {{HEIGHT_BITS{1'b0}}, 1'b1};
            end
            step_cost = COST_W'(d);
        end
    endfunction

    assign cfg_ready = 1'b1;

    // the compute stage waits only when it holds a result and out is full
    assign s1_retire = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_retire;
    assign in_acc    = in_valid && in_ready;

    assign col_end = (col_reg == side_m1_reg);
    assign is_last = col_end && (row_reg == side_m1_reg);

    // side clamp and scan position
    always_comb
    begin
        side_m1_next = side_m1_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        if (cfg_valid)
        begin
            if (grid_side == '0)
            begin
                side_m1_next = '0;
            end
            else if (32'(grid_side) > 32'(MAX_SIDE))
            begin
                side_m1_next = SIDE_MAX_M1;
            end
            else
            begin
                side_m1_next = IDX_W'(grid_side - 1'b1);
            end
            row_next = '0;
            col_next = '0;
        end
        else if (in_acc)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = is_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // cell cost from the left and upper neighbors
    always_comb
    begin
        left_sum = left_cost_reg + step_cost(left_h_reg, s1_h_reg);
        up_sum   = rd_data_reg.cost + step_cost(rd_data_reg.h, s1_h_reg);
        if (s1_has_left_reg && s1_has_up_reg)
        begin
            cell_cost = (up_sum < left_sum) ? up_sum : left_sum;
        end
        else if (s1_has_left_reg)
        begin
            cell_cost = left_sum;
        end
        else if (s1_has_up_reg)
        begin
            cell_cost = up_sum;
        end
        else
        begin
            cell_cost = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_retire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_retire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_m1_reg   <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            side_m1_reg   <= side_m1_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payload taken at accept; left neighbor and result taken at retire
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_h_reg        <= height;
            s1_addr_reg     <= col_reg;
            s1_has_up_reg   <= (row_reg != '0);
            s1_has_left_reg <= (col_reg != '0);
            s1_last_reg     <= is_last;
        end
        if (s1_retire)
        begin
            left_cost_reg <= cell_cost;
            left_h_reg    <= s1_h_reg;
        end
        if (s1_retire && s1_last_reg)
        begin
            out_cost_reg <= cell_cost;
        end
    end

    // line buffer: read the entry above at accept, write back at retire
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_retire)
        begin
            line_mem[s1_addr_reg] <= '{cost: cell_cost, h: s1_h_reg};
        end
    end

    assign out_valid  = out_valid_reg;
    assign total_cost = out_cost_reg;

    // checks
    a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_retire) |-> (s1_last_reg && out_valid_reg && !out_ready))
        else $error("compute stage stalled without a pending result");

    a_cfg_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (row_reg == '0 && col_reg == '0))
        else $error("scan position not reset by configuration write");

    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= side_m1_reg) && (col_reg <= side_m1_reg))
        else $error("scan position outside the grid");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result raised without a last cell");

endmodule : monotone_grid_path_cost
`default_nettype wire
